/* rtl/ifpyt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifpyt_pkg
// Shared types, codes and helpers for the sensor frame parser and yaw tracker.
// ----------------------------------------------------------------------------
package ifpyt_pkg;

   // frame bytes
   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TYPE_FIRST = 8'h51;
   localparam logic [7:0] TYPE_LAST  = 8'h54;
   localparam int         DATA_LEN   = 8;
   localparam int         CNT_W      = $clog2(DATA_LEN);

   // frame kinds after removing the type offset
   localparam logic [1:0] KIND_ANGLE = 2'd2;

   // angle wrap limits in raw units, wide enough for a raw difference
   localparam logic signed [17:0] HALF_TURN = 18'sd32768;
   localparam logic signed [17:0] FULL_TURN = 18'sd65536;

   // configuration port
   localparam int         CSR_INDEX_WIDTH  = 2;
   localparam int         CSR_DATA_WIDTH   = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIRECTION    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_ADVANCE = 2'd1;

   // queue depths
   localparam int CMD_DEPTH_DEFAULT = 2;
   localparam int RSP_DEPTH_DEFAULT = 2;

   typedef enum logic [1:0] {
      ACT_BYTE        = 2'd0,
      ACT_TRACK_RESET = 2'd1,
      ACT_SET_TARGET  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_TYPE   = 2'd1,
      PH_DATA   = 2'd2,
      PH_CHECK  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      OP_NONE        = 3'd0,
      OP_REJECT      = 3'd1,
      OP_FRAME       = 3'd2,
      OP_TRACK_RESET = 3'd3,
      OP_SET_TARGET  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_GOOD   = 2'd1,
      EV_REJECT = 2'd2
   } event_type;

   // word from the parser to the tracker
   typedef struct packed {
      op_type             op;
      logic [1:0]         kind;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
      logic signed [31:0] target;
      logic signed [33:0] stop;
   } cmd_type;

   // result word
   typedef struct packed {
      event_type          frame_event;
      logic [1:0]         kind;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
      logic signed [31:0] yaw;
      logic               hit;
      logic               angle_seen;
   } rsp_type;

   // stop point: subtract the margin from a positive goal, add it to any other goal
   function automatic logic signed [33:0] stop_point(input logic signed [31:0] goal,
                                                     input logic [15:0] adv);
      logic signed [33:0] g;
      logic signed [33:0] a;
      g = {{2{goal[31]}}, goal};
      a = {18'd0, adv};
      if (goal > 32'sd0) begin
         return g - a;
      end else begin
         return g + a;
      end
   endfunction

endpackage

/* rtl/imu_frame_parser_yaw_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_parser_yaw_tracker
// Sensor byte frame parser with wrapped yaw accumulator and turn target check.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_full is low and gives one result word per
// item, in order. The parser classifies each item as it is accepted and pushes
// a command word into a short queue; the tracker takes one command word per
// cycle while the result queue has room. An item's command word is held in the
// command queue, and its result word in the result queue until popped. The
// tracker's yaw difference, 32-bit accumulate and target compare form the
// longest path and set the one-word-per-cycle rate. Write configuration
// registers only while no item is in flight.
// ----------------------------------------------------------------------------
module imu_frame_parser_yaw_tracker #(
   parameter int CMD_DEPTH = ifpyt_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = ifpyt_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // item input
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [1:0]                             req_action,
   input  logic [7:0]                             req_rx_byte,
   input  logic signed [31:0]                     req_target,
   // results
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [1:0]                             rsp_frame_event,
   output logic [1:0]                             rsp_frame_kind,
   output logic signed [15:0]                     rsp_value_x,
   output logic signed [15:0]                     rsp_value_y,
   output logic signed [15:0]                     rsp_value_z,
   output logic signed [31:0]                     rsp_yaw_accumulated,
   output logic                                   rsp_target_hit,
   output logic                                   rsp_angle_seen,
   // configuration
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ifpyt_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ifpyt_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import ifpyt_pkg::*;

   logic        direction_ff;
   logic [15:0] stop_advance_ff;
   logic        accept;
   cmd_type     cmd_front, cmd_back;
   logic [$bits(cmd_type)-1:0] cmd_back_bits;
   logic        cmd_full, cmd_empty;
   logic        rsp_full, fire;
   rsp_type     rsp_back, rsp_head;
   logic [$bits(rsp_type)-1:0] rsp_head_bits;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !cmd_full;
   assign req_full  = cmd_full;
   assign fire      = !cmd_empty && !rsp_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff    <= 1'b0;
         stop_advance_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DIRECTION) begin
            direction_ff <= csr_data[0];
         end else if (csr_index == CSR_STOP_ADVANCE) begin
            stop_advance_ff <= csr_data[15:0];
         end
      end
   end

   ifpyt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (req_action),
      .rx_byte      (req_rx_byte),
      .target_value (req_target),
      .stop_advance (stop_advance_ff),
      .cmd          (cmd_front)
   );

   ifpyt_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (cmd_front),
      .full      (cmd_full),
      .pop       (fire),
      .pop_data  (cmd_back_bits),
      .empty     (cmd_empty)
   );

   assign cmd_back = cmd_type'(cmd_back_bits);

   ifpyt_back u_back (
      .clock              (clock),
      .reset              (reset),
      .fire               (fire),
      .cmd                (cmd_back),
      .direction_negative (direction_ff),
      .stop_advance       (stop_advance_ff),
      .rsp                (rsp_back)
   );

   ifpyt_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (rsp_back),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head_bits),
      .empty     (rsp_empty)
   );

   // unpack the oldest result word
   assign rsp_head            = rsp_type'(rsp_head_bits);
   assign rsp_frame_event     = rsp_head.frame_event;
   assign rsp_frame_kind      = rsp_head.kind;
   assign rsp_value_x         = rsp_head.vx;
   assign rsp_value_y         = rsp_head.vy;
   assign rsp_value_z         = rsp_head.vz;
   assign rsp_yaw_accumulated = rsp_head.yaw;
   assign rsp_target_hit      = rsp_head.hit;
   assign rsp_angle_seen      = rsp_head.angle_seen;

endmodule

/* rtl/ifpyt_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifpyt_fifo
// Small synchronous queue in flip-flops; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module ifpyt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/ifpyt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifpyt_front
// Frame parser: walks header, type, data and checksum bytes and turns each
// accepted item into one command word for the tracker.
// ----------------------------------------------------------------------------
module ifpyt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [1:0]                action,
   input  logic [7:0]                rx_byte,
   input  logic signed [31:0]        target_value,
   input  logic [15:0]               stop_advance,
   output ifpyt_pkg::cmd_type        cmd
);
   import ifpyt_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [1:0]       kind_ff, kind_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       payload_ff [DATA_LEN];
   logic             payload_we;
   logic             type_ok;
   logic [7:0]       type_off;

   assign type_ok  = (rx_byte >= TYPE_FIRST) && (rx_byte <= TYPE_LAST);
   assign type_off = rx_byte - TYPE_FIRST;

   // next phase and command word
   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      payload_we = 1'b0;
      cmd        = '0;
      cmd.op     = OP_NONE;
      unique case (action_type'(action))
         ACT_BYTE: begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (rx_byte == HDR_BYTE) begin
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  if (type_ok) begin
                     kind_in  = type_off[1:0];
                     count_in = '0;
                     sum_in   = HDR_BYTE + rx_byte;
                     phase_in = PH_DATA;
                  end else begin
                     cmd.op   = OP_REJECT;
                     phase_in = (rx_byte == HDR_BYTE) ? PH_TYPE : PH_HEADER;
                  end
               end
               PH_DATA: begin
                  payload_we = 1'b1;
                  sum_in     = sum_ff + rx_byte;
                  count_in   = count_ff + 1'b1;
                  if (count_ff == CNT_W'(DATA_LEN - 1)) begin
                     phase_in = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  if (sum_ff == rx_byte) begin
                     cmd.op   = OP_FRAME;
                     cmd.kind = kind_ff;
                     cmd.vx   = {payload_ff[1], payload_ff[0]};
                     cmd.vy   = {payload_ff[3], payload_ff[2]};
                     cmd.vz   = {payload_ff[5], payload_ff[4]};
                  end else begin
                     cmd.op = OP_REJECT;
                  end
                  phase_in = (rx_byte == HDR_BYTE) ? PH_TYPE : PH_HEADER;
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end
         ACT_TRACK_RESET: begin
            cmd.op = OP_TRACK_RESET;
         end
         ACT_SET_TARGET: begin
            cmd.op     = OP_SET_TARGET;
            cmd.target = target_value;
            cmd.stop   = stop_point(target_value, stop_advance);
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

   // hold parser state between bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         kind_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // capture data bytes
   always_ff @(posedge clock) begin
      if (accept && payload_we) begin
         payload_ff[count_ff] <= rx_byte;
      end
   end

endmodule

/* rtl/ifpyt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifpyt_back
// Yaw tracker: runs one command word per cycle while fire is high, accumulates wrapped yaw
// differences, checks the turn target and forms the result word.
// ----------------------------------------------------------------------------
module ifpyt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  ifpyt_pkg::cmd_type   cmd,
   input  logic                 direction_negative,
   input  logic [15:0]          stop_advance,
   output ifpyt_pkg::rsp_type   rsp
);
   import ifpyt_pkg::*;

   logic               started_ff, started_in;
   logic signed [15:0] prev_ff, prev_in;
   logic signed [15:0] latest_ff, latest_in;
   logic signed [31:0] sum_ff, sum_in;
   logic signed [31:0] goal_ff, goal_in;
   logic signed [33:0] stop_ff, stop_in;
   logic               active_ff, active_in;
   logic               angle_ff, angle_in;
   logic signed [17:0] d_raw, d_wrap, d_dir;
   logic signed [33:0] stop_use, sum_wide;
   logic               hit;

   // wrapped yaw difference against the previous angle
   always_comb begin
      d_raw = {{2{cmd.vz[15]}}, cmd.vz} - {{2{prev_ff[15]}}, prev_ff};
      if (d_raw > HALF_TURN) begin
         d_wrap = d_raw - FULL_TURN;
      end else if (d_raw < -HALF_TURN) begin
         d_wrap = d_raw + FULL_TURN;
      end else begin
         d_wrap = d_raw;
      end
      d_dir = direction_negative ? -d_wrap : d_wrap;
   end

   // apply the command, then check the target
   always_comb begin
      started_in = started_ff;
      prev_in    = prev_ff;
      latest_in  = latest_ff;
      sum_in     = sum_ff;
      goal_in    = goal_ff;
      active_in  = active_ff;
      angle_in   = angle_ff;
      stop_use   = stop_ff;
      unique case (cmd.op)
         OP_FRAME: begin
            if (cmd.kind == KIND_ANGLE) begin
               latest_in = cmd.vz;
               angle_in  = 1'b1;
               prev_in   = cmd.vz;
               started_in = 1'b1;
               if (started_ff) begin
                  sum_in = sum_ff + {{14{d_dir[17]}}, d_dir};
               end
            end
         end
         OP_TRACK_RESET: begin
            sum_in    = '0;
            active_in = 1'b0;
            if (angle_ff) begin
               prev_in    = latest_ff;
               started_in = 1'b1;
            end else begin
               started_in = 1'b0;
            end
         end
         OP_SET_TARGET: begin
            goal_in   = cmd.target;
            active_in = 1'b1;
            stop_use  = cmd.stop;
         end
         default: begin
         end
      endcase

      sum_wide = {{2{sum_in[31]}}, sum_in};
      hit      = 1'b0;
      if (active_in) begin
         if (goal_in > 32'sd0) begin
            hit = (sum_wide >= stop_use);
         end else begin
            hit = (sum_wide <= stop_use);
         end
      end
      if (hit) begin
         active_in = 1'b0;
      end
   end

   // track the stop point of the held goal
   assign stop_in = (fire && cmd.op == OP_SET_TARGET) ? cmd.stop
                                                      : stop_point(goal_ff, stop_advance);

   // result word
   always_comb begin
      rsp            = '0;
      rsp.frame_event = EV_NONE;
      if (cmd.op == OP_FRAME) begin
         rsp.frame_event = EV_GOOD;
         rsp.kind        = cmd.kind;
         rsp.vx          = cmd.vx;
         rsp.vy          = cmd.vy;
         rsp.vz          = cmd.vz;
      end else if (cmd.op == OP_REJECT) begin
         rsp.frame_event = EV_REJECT;
      end
      rsp.yaw        = sum_in;
      rsp.hit        = hit;
      rsp.angle_seen = angle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         prev_ff    <= '0;
         latest_ff  <= '0;
         sum_ff     <= '0;
         goal_ff    <= '0;
         active_ff  <= 1'b0;
         angle_ff   <= 1'b0;
         stop_ff    <= '0;
      end else begin
         stop_ff <= stop_in;
         if (fire) begin
            started_ff <= started_in;
            prev_ff    <= prev_in;
            latest_ff  <= latest_in;
            sum_ff     <= sum_in;
            goal_ff    <= goal_in;
            active_ff  <= active_in;
            angle_ff   <= angle_in;
         end
      end
   end

endmodule
